// ----- hdl/tmlt_pkg.sv -----
// Package for the tabu move list: table sizes, field widths, entry layout
// and the sequencer state and opcode types.
// No dependencies; used by tabu_move_list_with_tenure_unit.
`timescale 1ns / 1ps
`default_nettype none

package tmlt_pkg;

    localparam int CAPACITY   = 64;
    localparam int INDEX_BITS = 10;
    localparam int LIFE_BITS  = 10;
    localparam int KIND_BITS  = 2;
    localparam int OP_BITS    = 2;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CFG_W      = 7;

    localparam int IN_FIELDS_W = KIND_BITS + 2 * INDEX_BITS + LIFE_BITS;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 + CNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int USER_W       = ((OP_BITS + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(64);

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [LIFE_BITS-1:0]  life;
        logic [INDEX_BITS-1:0] second;
        logic [INDEX_BITS-1:0] first;
        logic [KIND_BITS-1:0]  kind;
    } t_entry;

endpackage

`default_nettype wire

// ----- hdl/tabu_move_list_with_tenure_unit.sv -----
// Tabu move list with tenure: one entry memory walked by a single compare
// and decrement unit under a small sequencer. Depends on tmlt_pkg.
//
// Add and unused opcodes raise the result in the cycle after accept; query and
// tick first walk the entry memory one read per cycle (one entry compared or
// aged and compacted a cycle), then raise the result.
// One word in flight at a time: s_axis_tready is high only while idle.
// Reset (synchronous, active low): table empty, capacity 64, no result held.
`timescale 1ns / 1ps
`default_nettype none

module tabu_move_list_with_tenure_unit (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_wr_en,
    input  wire [tmlt_pkg::CFG_W-1:0]          i_cfg_wr_data,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // move_kind[1:0], first_index[11:2], second_index[21:12], tenure[31:22]
    input  wire [tmlt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // opcode[1:0], zero fill above
    input  wire [tmlt_pkg::USER_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // hit[0], accepted[1], occupancy[8:2], zero fill above
    output logic [tmlt_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int AW = tmlt_pkg::ADDR_W;
    localparam int CW = tmlt_pkg::CNT_W;

    // entry memory
    tmlt_pkg::t_entry r_mem [tmlt_pkg::CAPACITY];
    tmlt_pkg::t_entry r_rdata;

    tmlt_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_keep, n_keep;
    logic             r_pend, n_pend;
    logic             r_hit, n_hit;
    logic             r_acc, n_acc;
    tmlt_pkg::t_op    r_op, n_op;
    tmlt_pkg::t_entry r_key, n_key;
    logic [tmlt_pkg::CFG_W-1:0] r_cap;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    tmlt_pkg::t_entry mem_wdata;
    logic             mem_re;

    logic             in_fire;
    logic             out_fire;
    logic [CW-1:0]    eff_cap;
    logic             scan_done;
    logic             key_match;
    tmlt_pkg::t_entry in_entry;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign in_entry = tmlt_pkg::t_entry'(s_axis_tdata[tmlt_pkg::IN_FIELDS_W-1:0]);
    assign eff_cap  = (r_cap > tmlt_pkg::CFG_W'(tmlt_pkg::CAPACITY))
                      ? CW'(tmlt_pkg::CAPACITY) : CW'(r_cap);
    assign scan_done = !r_pend && (r_idx >= r_count);
    assign key_match = (r_rdata.kind == r_key.kind) && (r_rdata.first == r_key.first)
                       && (r_rdata.second == r_key.second);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tmlt_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (s_axis_tuser[tmlt_pkg::OP_BITS-1:0] == tmlt_pkg::OP_QUERY
                        || s_axis_tuser[tmlt_pkg::OP_BITS-1:0] == tmlt_pkg::OP_TICK) begin
                        n_state = tmlt_pkg::ST_SCAN;
                    end else begin
                        n_state = tmlt_pkg::ST_RESP;
                    end
                end
            end
            tmlt_pkg::ST_SCAN: begin
                if (scan_done) n_state = tmlt_pkg::ST_RESP;
            end
            tmlt_pkg::ST_RESP: begin
                if (out_fire) n_state = tmlt_pkg::ST_IDLE;
            end
            default: n_state = tmlt_pkg::ST_IDLE;
        endcase
    end

    // datapath control and outputs
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_keep    = r_keep;
        n_pend    = 1'b0;
        n_hit     = r_hit;
        n_acc     = r_acc;
        n_op      = r_op;
        n_key     = r_key;
        mem_we    = 1'b0;
        mem_waddr = r_keep[AW-1:0];
        mem_wdata = r_rdata;
        mem_re    = 1'b0;
        s_axis_tready = (r_state == tmlt_pkg::ST_IDLE);
        m_axis_tvalid = (r_state == tmlt_pkg::ST_RESP);
        m_axis_tdata  = '0;
        m_axis_tdata[tmlt_pkg::OUT_FIELDS_W-1:0] = {r_count, r_acc, r_hit};
        unique case (r_state)
            tmlt_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_op   = tmlt_pkg::t_op'(s_axis_tuser[tmlt_pkg::OP_BITS-1:0]);
                    n_key  = in_entry;
                    n_hit  = 1'b0;
                    n_acc  = 1'b0;
                    n_idx  = '0;
                    n_keep = '0;
                    // append at the tail when there is room
                    if (s_axis_tuser[tmlt_pkg::OP_BITS-1:0] == tmlt_pkg::OP_ADD
                        && r_count < eff_cap) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[AW-1:0];
                        mem_wdata = in_entry;
                        n_count   = r_count + CW'(1);
                        n_acc     = 1'b1;
                    end
                end
            end
            tmlt_pkg::ST_SCAN: begin
                // handle the entry read last cycle
                if (r_pend) begin
                    if (r_op == tmlt_pkg::OP_QUERY) begin
                        if (key_match) n_hit = 1'b1;
                    end else if (r_rdata.life > tmlt_pkg::LIFE_BITS'(1)) begin
                        mem_we         = 1'b1;
                        mem_waddr      = r_keep[AW-1:0];
                        mem_wdata      = r_rdata;
                        mem_wdata.life = r_rdata.life - tmlt_pkg::LIFE_BITS'(1);
                        n_keep         = r_keep + CW'(1);
                    end
                end
                // advance the read pointer
                if (r_idx < r_count) begin
                    mem_re = 1'b1;
                    n_idx  = r_idx + CW'(1);
                    n_pend = 1'b1;
                end
                if (scan_done && r_op == tmlt_pkg::OP_TICK) n_count = r_keep;
            end
            tmlt_pkg::ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmlt_pkg::ST_IDLE;
            r_count <= '0;
            r_cap   <= tmlt_pkg::CAP_RESET;
            r_pend  <= 1'b0;
            r_idx   <= '0;
            r_keep  <= '0;
            r_hit   <= 1'b0;
            r_acc   <= 1'b0;
            r_op    <= tmlt_pkg::OP_ADD;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_idx   <= n_idx;
            r_keep  <= n_keep;
            r_hit   <= n_hit;
            r_acc   <= n_acc;
            r_op    <= n_op;
            if (i_cfg_wr_en) r_cap <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(tmlt_pkg::CAPACITY))
        else $error("stored count above table size");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is held");

    a_keep_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tmlt_pkg::ST_SCAN) |-> (r_keep <= r_idx))
        else $error("compaction pointer ahead of read pointer");

    a_acc_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_acc) |-> (r_count != '0))
        else $error("accepted add with empty table");

endmodule

`default_nettype wire
